FILE: rtl/core/slu_pkg.sv
// Shared types, constants and helpers for the string literal unescape block.
// No dependencies.
package slu_pkg;

  typedef enum logic [1:0] {
    MODE_TEXT,
    MODE_ESC,
    MODE_HEX
  } mode_t;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_CLOSE,
    KIND_BADHEX,
    KIND_EOF
  } kind_t;

  localparam int unsigned MaxResults = 3;

  localparam logic [7:0]  CharQuote     = 8'h22;
  localparam logic [7:0]  CharBackslash = 8'h5c;
  localparam logic [7:0]  CharN         = 8'h6e;
  localparam logic [7:0]  CharU         = 8'h75;
  localparam logic [7:0]  LineFeed      = 8'h0a;

  localparam logic [15:0] Utf8OneLimit  = 16'h0080;
  localparam logic [15:0] Utf8TwoLimit  = 16'h0800;
  localparam logic [7:0]  Utf8Cont      = 8'h80;
  localparam logic [7:0]  Utf8Lead2     = 8'hc0;
  localparam logic [7:0]  Utf8Lead3     = 8'he0;

  // {valid, value}
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/string_literal_unescape_utf8.sv
// String literal unescape decoder with UTF-8 output, top level.
// Depends on slu_pkg.
// The first result beat of an accepted source beat is registered and valid in the next cycle.
// Throughput: one source beat per cycle while the result side does not stall;
// a \u escape that encodes to two or three UTF-8 bytes holds the source side
// while the three-entry result buffer drains, one beat per cycle unless stalled.
// Reset: synchronous rst returns to text mode and empties the result buffer.
module string_literal_unescape_utf8 (
  input  logic       clk,
  input  logic       rst,
  input  logic       src_valid,
  output logic       src_stall,
  input  logic [7:0] source_byte,
  input  logic       end_of_input,
  output logic       dst_valid,
  input  logic       dst_stall,
  output logic [7:0] out_byte,
  output logic [1:0] kind,
  output logic [1:0] bad_digit_index,
  output logic       last
);

  slu_pkg::mode_t mode, mode_next;
  logic [1:0]     digit_count, digit_count_next;
  logic [15:0]    code_accum, code_accum_next;

  logic [1:0]     cnt;
  logic [7:0]     e_byte [slu_pkg::MaxResults];
  slu_pkg::kind_t e_kind [slu_pkg::MaxResults];
  logic [1:0]     e_idx  [slu_pkg::MaxResults];

  logic [1:0]     n_new;
  logic [7:0]     nb [slu_pkg::MaxResults];
  slu_pkg::kind_t nk;
  logic [1:0]     ni;
  logic [4:0]     hv;
  logic [15:0]    cp;
  logic           accept, pop;

  assign accept    = src_valid && !src_stall;
  assign pop       = dst_valid && !dst_stall;
  assign src_stall = (cnt > 2'd1) || (cnt == 2'd1 && dst_stall);

  assign dst_valid       = (cnt != 2'd0);
  assign out_byte        = e_byte[0];
  assign kind            = e_kind[0];
  assign bad_digit_index = e_idx[0];
  assign last            = (cnt == 2'd1);

  assign hv = slu_pkg::hex_value(source_byte);
  assign cp = {code_accum[11:0], hv[3:0]};

  always_comb begin
    mode_next        = mode;
    digit_count_next = digit_count;
    code_accum_next  = code_accum;
    n_new            = 2'd0;
    nb[0]            = 8'd0;
    nb[1]            = 8'd0;
    nb[2]            = 8'd0;
    nk               = slu_pkg::KIND_DATA;
    ni               = 2'd0;
    if (end_of_input) begin
      n_new            = 2'd1;
      nk               = slu_pkg::KIND_EOF;
      mode_next        = slu_pkg::MODE_TEXT;
      digit_count_next = 2'd0;
      code_accum_next  = 16'd0;
    end else begin
      case (mode)
        slu_pkg::MODE_ESC: begin
          digit_count_next = 2'd0;
          code_accum_next  = 16'd0;
          if (source_byte == slu_pkg::CharU) begin
            mode_next = slu_pkg::MODE_HEX;
          end else begin
            mode_next = slu_pkg::MODE_TEXT;
            n_new     = 2'd1;
            nb[0]     = (source_byte == slu_pkg::CharN) ? slu_pkg::LineFeed : source_byte;
          end
        end
        slu_pkg::MODE_HEX: begin
          if (!hv[4]) begin
            n_new            = 2'd1;
            nk               = slu_pkg::KIND_BADHEX;
            ni               = digit_count;
            mode_next        = slu_pkg::MODE_TEXT;
            digit_count_next = 2'd0;
            code_accum_next  = 16'd0;
          end else if (digit_count == 2'd3) begin
            mode_next        = slu_pkg::MODE_TEXT;
            digit_count_next = 2'd0;
            code_accum_next  = 16'd0;
            if (cp < slu_pkg::Utf8OneLimit) begin
              n_new = 2'd1;
              nb[0] = cp[7:0];
            end else if (cp < slu_pkg::Utf8TwoLimit) begin
              n_new = 2'd2;
              nb[0] = slu_pkg::Utf8Lead2 | {3'd0, cp[10:6]};
              nb[1] = slu_pkg::Utf8Cont | {2'd0, cp[5:0]};
            end else begin
              n_new = 2'd3;
              nb[0] = slu_pkg::Utf8Lead3 | {4'd0, cp[15:12]};
              nb[1] = slu_pkg::Utf8Cont | {2'd0, cp[11:6]};
              nb[2] = slu_pkg::Utf8Cont | {2'd0, cp[5:0]};
            end
          end else begin
            code_accum_next  = cp;
            digit_count_next = digit_count + 2'd1;
          end
        end
        default: begin
          mode_next = slu_pkg::MODE_TEXT;
          if (source_byte == slu_pkg::CharQuote) begin
            n_new = 2'd1;
            nk    = slu_pkg::KIND_CLOSE;
          end else if (source_byte == slu_pkg::CharBackslash) begin
            mode_next = slu_pkg::MODE_ESC;
          end else begin
            n_new = 2'd1;
            nb[0] = source_byte;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= slu_pkg::MODE_TEXT;
      digit_count <= 2'd0;
      code_accum  <= 16'd0;
    end else if (accept) begin
      mode        <= mode_next;
      digit_count <= digit_count_next;
      code_accum  <= code_accum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (accept) begin
      cnt <= n_new;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  // load a fresh beat group, or advance the buffer by one beat
  always_ff @(posedge clk) begin
    if (accept) begin
      e_byte[0] <= nb[0];
      e_byte[1] <= nb[1];
      e_byte[2] <= nb[2];
      e_kind[0] <= nk;
      e_kind[1] <= slu_pkg::KIND_DATA;
      e_kind[2] <= slu_pkg::KIND_DATA;
      e_idx[0]  <= ni;
      e_idx[1]  <= 2'd0;
      e_idx[2]  <= 2'd0;
    end else if (pop) begin
      e_byte[0] <= e_byte[1];
      e_byte[1] <= e_byte[2];
      e_kind[0] <= e_kind[1];
      e_kind[1] <= e_kind[2];
      e_idx[0]  <= e_idx[1];
      e_idx[1]  <= e_idx[2];
    end
  end

  a_eof_reported: assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_input) |=> (dst_valid && kind == slu_pkg::KIND_EOF && last))
    else $error("end of input not reported as a single final beat");

  a_digits_only_in_hex: assert property (@(posedge clk) disable iff (rst)
    (digit_count != 2'd0) |-> (mode == slu_pkg::MODE_HEX))
    else $error("hex digit count set outside hex mode");

  a_multi_beat_is_data: assert property (@(posedge clk) disable iff (rst)
    (cnt > 2'd1) |-> (kind == slu_pkg::KIND_DATA && !src_stall == 1'b0))
    else $error("multi-beat result group is not data or source not held");

endmodule

FILE: sim/string_literal_unescape_utf8_test.sv
// Testbench for string_literal_unescape_utf8: random and directed literal bodies,
// with a local escape/UTF-8 decoder predicting every result beat.
// Depends on slu_pkg and the string_literal_unescape_utf8 RTL.
module string_literal_unescape_utf8_test;
  timeunit 1ns;
  timeprecision 1ps;

  import slu_pkg::*;

  localparam int RandomItems = 410;
  localparam int CycleLimit  = 200000;

  typedef struct packed {
    logic [7:0] b;
    logic       eoi;
    logic       hold;
  } src_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_t      kind;
    logic [1:0] idx;
    logic       last;
  } dec_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       src_valid = 1'b0;
  logic       src_stall;
  logic [7:0] source_byte = 8'h00;
  logic       end_of_input = 1'b0;
  logic       dst_valid;
  logic       dst_stall = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic [1:0] bad_digit_index;
  logic       last;

  src_item_t   pend_q[$];
  dec_result_t decoded_q[$];
  int          err_count = 0;
  int          item_count = 0;
  int          cycles = 0;
  int          src_gap = 0;
  int          dst_gap = 0;
  logic        quiet = 1'b0;

  mode_t       dec_mode = MODE_TEXT;
  logic [1:0]  dec_digits = 2'd0;
  logic [15:0] dec_code = 16'h0000;

  string_literal_unescape_utf8 u_top (
    .clk(clk),
    .rst(rst),
    .src_valid(src_valid),
    .src_stall(src_stall),
    .source_byte(source_byte),
    .end_of_input(end_of_input),
    .dst_valid(dst_valid),
    .dst_stall(dst_stall),
    .out_byte(out_byte),
    .kind(kind),
    .bad_digit_index(bad_digit_index),
    .last(last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int nibble_of(input logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b) - int'("0");
    if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
    if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
    if (nib < 4'd10) return 8'("0") + 8'(nib);
    return (upper ? 8'("A") : 8'("a")) + 8'(nib) - 8'd10;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic eoi);
    dec_result_t r[3];
    int          n;
    int          nib;
    logic [15:0] cp;
    n = 0;
    if (eoi) begin
      r[0] = '{8'h00, KIND_EOF, 2'd0, 1'b0};
      n = 1;
      dec_mode = MODE_TEXT;
    end else begin
      case (dec_mode)
        MODE_ESC: begin
          if (b == CharU) begin
            dec_mode = MODE_HEX;
            dec_digits = 2'd0;
            dec_code = 16'h0000;
          end else begin
            r[0] = '{(b == CharN) ? LineFeed : b, KIND_DATA, 2'd0, 1'b0};
            n = 1;
            dec_mode = MODE_TEXT;
          end
        end
        MODE_HEX: begin
          nib = nibble_of(b);
          if (nib < 0) begin
            r[0] = '{8'h00, KIND_BADHEX, dec_digits, 1'b0};
            n = 1;
            dec_mode = MODE_TEXT;
          end else begin
            cp = {dec_code[11:0], 4'(nib)};
            dec_code = cp;
            if (dec_digits == 2'd3) begin
              if (cp < Utf8OneLimit) begin
                r[0] = '{cp[7:0], KIND_DATA, 2'd0, 1'b0};
                n = 1;
              end else if (cp < Utf8TwoLimit) begin
                r[0] = '{Utf8Lead2 | {3'b000, cp[10:6]}, KIND_DATA, 2'd0, 1'b0};
                r[1] = '{Utf8Cont | {2'b00, cp[5:0]}, KIND_DATA, 2'd0, 1'b0};
                n = 2;
              end else begin
                r[0] = '{Utf8Lead3 | {4'b0000, cp[15:12]}, KIND_DATA, 2'd0, 1'b0};
                r[1] = '{Utf8Cont | {2'b00, cp[11:6]}, KIND_DATA, 2'd0, 1'b0};
                r[2] = '{Utf8Cont | {2'b00, cp[5:0]}, KIND_DATA, 2'd0, 1'b0};
                n = 3;
              end
              dec_mode = MODE_TEXT;
            end else begin
              dec_digits = dec_digits + 2'd1;
            end
          end
        end
        default: begin
          dec_mode = MODE_TEXT;
          if (b == CharQuote) begin
            r[0] = '{8'h00, KIND_CLOSE, 2'd0, 1'b0};
            n = 1;
          end else if (b == CharBackslash) begin
            dec_mode = MODE_ESC;
          end else begin
            r[0] = '{b, KIND_DATA, 2'd0, 1'b0};
            n = 1;
          end
        end
      endcase
    end
    if (dec_mode == MODE_TEXT) begin
      dec_digits = 2'd0;
      dec_code = 16'h0000;
    end
    for (int i = 0; i < n; i++) begin
      r[i].last = (i == n - 1);
      decoded_q.push_back(r[i]);
    end
  endfunction

  function automatic void push_item(input logic [7:0] b, input logic eoi);
    pend_q.push_back('{b, eoi, 1'b0});
    item_count++;
  endfunction

  function automatic void push_hex_digits(input logic [15:0] cp, input int count);
    for (int i = 0; i < count; i++) begin
      push_item(hex_char(cp[15 - 4 * i -: 4], 1'($urandom_range(0, 1))), 1'b0);
    end
  endfunction

  function automatic void push_unicode(input logic [15:0] cp);
    push_item(CharBackslash, 1'b0);
    push_item(CharU, 1'b0);
    push_hex_digits(cp, 4);
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (nibble_of(b) >= 0);
    return b;
  endfunction

  function automatic void push_random_sequence();
    int          sel;
    int          k;
    logic [7:0]  b;
    logic [15:0] cp;
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      push_item(8'($urandom_range(0, 255)), 1'b0);
    end else if (sel < 38) begin
      push_item(CharQuote, 1'b0);
    end else if (sel < 50) begin
      push_item(CharBackslash, 1'b0);
      case ($urandom_range(0, 3))
        0: b = CharN;
        1: b = CharQuote;
        2: b = CharBackslash;
        default: do b = 8'($urandom_range(0, 255)); while (b == CharU);
      endcase
      push_item(b, 1'b0);
    end else if (sel < 78) begin
      case ($urandom_range(0, 2))
        0: cp = 16'($urandom_range(0, 16'h007f));
        1: cp = 16'($urandom_range(16'h0080, 16'h07ff));
        default: cp = 16'($urandom_range(16'h0800, 16'hffff));
      endcase
      push_unicode(cp);
    end else if (sel < 88) begin
      push_item(CharBackslash, 1'b0);
      push_item(CharU, 1'b0);
      push_hex_digits(16'($urandom_range(0, 16'hffff)), $urandom_range(0, 3));
      push_item(non_hex_byte(), 1'b0);
    end else if (sel < 95) begin
      k = $urandom_range(0, 5);
      if (k >= 1) push_item(CharBackslash, 1'b0);
      if (k >= 2) push_item(CharU, 1'b0);
      if (k >= 3) push_hex_digits(16'($urandom_range(0, 16'hffff)), k - 2);
      push_item(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      push_item(8'($urandom_range(0, 255)), 1'b1);
    end
  endfunction

  always @(posedge clk) begin : drive
    src_item_t nxt;
    if (rst) begin
      src_valid <= 1'b0;
      src_gap <= 0;
    end else begin
      quiet <= (pend_q.size() < 60);
      if (src_valid && !src_stall) decode_byte(source_byte, end_of_input);
      if (!src_valid || !src_stall) begin
        if (src_gap != 0) begin
          src_valid <= 1'b0;
          src_gap <= src_gap - 1;
        end else if (pend_q.size() == 0) begin
          src_valid <= 1'b0;
        end else if (pend_q[0].hold && decoded_q.size() != 0) begin
          src_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
          src_valid <= 1'b0;
          src_gap <= $urandom_range(0, 7);
        end else begin
          nxt = pend_q.pop_front();
          src_valid <= 1'b1;
          source_byte <= nxt.b;
          end_of_input <= nxt.eoi;
        end
      end
    end
  end

  always @(posedge clk) begin : watch
    dec_result_t want;
    if (rst) begin
      dst_stall <= 1'b0;
      dst_gap <= 0;
    end else begin
      if (dst_valid && !dst_stall) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected result beat: out_byte %h kind %0d", out_byte, kind);
          err_count++;
        end else begin
          want = decoded_q.pop_front();
          if (out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, out_byte);
            err_count++;
          end
          if (kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind);
            err_count++;
          end
          if (bad_digit_index !== want.idx) begin
            $error("bad_digit_index: expected %0d, got %0d", want.idx, bad_digit_index);
            err_count++;
          end
          if (last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last);
            err_count++;
          end
        end
      end
      if (dst_gap != 0) begin
        dst_stall <= 1'b1;
        dst_gap <= dst_gap - 1;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        dst_stall <= 1'b1;
        dst_gap <= $urandom_range(0, 7);
      end else begin
        dst_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int directed_count;
    push_item(8'h00, 1'b0);
    push_item(8'hff, 1'b0);
    push_item(CharQuote, 1'b0);
    push_item(CharBackslash, 1'b0);
    push_item(CharN, 1'b0);
    push_item(CharBackslash, 1'b0);
    push_item(CharQuote, 1'b0);
    push_item(CharBackslash, 1'b0);
    push_item(CharBackslash, 1'b0);
    push_unicode(16'hffff);
    push_unicode(16'h07ff);
    push_item(CharBackslash, 1'b0);
    push_item(CharU, 1'b0);
    push_item(8'("g"), 1'b0);
    push_item(8'h5a, 1'b1);
    directed_count = item_count;
    while (item_count < directed_count + RandomItems) push_random_sequence();
    pend_q[directed_count].hold = 1'b1;
    for (int i = 0; i < 3; i++) begin
      pend_q[$urandom_range(directed_count + 1, pend_q.size() - 1)].hold = 1'b1;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pend_q.size() != 0 || src_valid || decoded_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (decoded_q.size() != 0) begin
      $error("%0d expected result beats never arrived", decoded_q.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
